/* rtl/core/laau_pkg.sv */
package laau_pkg;

  localparam int unsigned STEP_W  = 5;
  localparam int unsigned EXPO_W  = 16;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [STEP_W-1:0] DEFAULT_STEP = 5'd16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_SKIP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INCREMENT   = 3'd7;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2
  } ramp_mode_t;

  typedef struct packed {
    logic [CNT_W-1:0]  frame_skip_threshold;
    logic [EXPO_W-1:0] exposure_entry_high;
    logic [EXPO_W-1:0] exposure_entry_low;
    logic [EXPO_W-1:0] exposure_keep_high;
    logic [EXPO_W-1:0] exposure_keep_low;
    logic [STEP_W-1:0] step_limit_high;
    logic [STEP_W-1:0] step_limit_low;
    logic [STEP_W-1:0] step_increment;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  frame_counter;
    ramp_mode_t        ramp_mode;
    logic [STEP_W-1:0] drive_step;
    logic              change_flag;
    logic              asleep;
  } state_t;

endpackage

/* rtl/core/laau_cfg_regs.sv */
module laau_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [laau_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [laau_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output laau_pkg::cfg_t                     cfg
);

  laau_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_skip_threshold <= 8'd8;
      cfg_r.exposure_entry_high  <= 16'd400;
      cfg_r.exposure_entry_low   <= 16'd200;
      cfg_r.exposure_keep_high   <= 16'd350;
      cfg_r.exposure_keep_low    <= 16'd250;
      cfg_r.step_limit_high      <= 5'd31;
      cfg_r.step_limit_low       <= 5'd1;
      cfg_r.step_increment       <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        laau_pkg::REG_FRAME_SKIP: begin
          cfg_r.frame_skip_threshold <= cfg_wdata[laau_pkg::CNT_W-1:0];
        end
        laau_pkg::REG_ENTRY_HIGH: begin
          cfg_r.exposure_entry_high <= cfg_wdata;
        end
        laau_pkg::REG_ENTRY_LOW: begin
          cfg_r.exposure_entry_low <= cfg_wdata;
        end
        laau_pkg::REG_KEEP_HIGH: begin
          cfg_r.exposure_keep_high <= cfg_wdata;
        end
        laau_pkg::REG_KEEP_LOW: begin
          cfg_r.exposure_keep_low <= cfg_wdata;
        end
        laau_pkg::REG_LIMIT_HIGH: begin
          cfg_r.step_limit_high <= cfg_wdata[laau_pkg::STEP_W-1:0];
        end
        laau_pkg::REG_LIMIT_LOW: begin
          cfg_r.step_limit_low <= cfg_wdata[laau_pkg::STEP_W-1:0];
        end
        laau_pkg::REG_INCREMENT: begin
          cfg_r.step_increment <= cfg_wdata[laau_pkg::STEP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/laau_step_logic.sv */
module laau_step_logic (
  input  laau_pkg::cfg_t                    cfg,
  input  laau_pkg::state_t                  cur,
  input  logic                              action,
  input  logic [laau_pkg::EXPO_W-1:0]       exposure_line,
  output laau_pkg::state_t                  nxt
);

  logic [laau_pkg::STEP_W-1:0] s;
  logic [laau_pkg::STEP_W-1:0] hi;
  logic [laau_pkg::STEP_W-1:0] lo;
  logic [laau_pkg::STEP_W:0]   s_up;
  logic [laau_pkg::STEP_W:0]   lo_inc;
  logic [laau_pkg::STEP_W-1:0] s_dn;
  logic                        at_floor;
  laau_pkg::ramp_mode_t        mode_eff;
  logic [laau_pkg::CNT_W-1:0]  cnt_eff;

  assign s        = cur.drive_step;
  assign hi       = cfg.step_limit_high;
  assign lo       = cfg.step_limit_low;
  // One extra bit keeps the sums from wrapping before the compares.
  assign s_up     = {1'b0, s} + {1'b0, cfg.step_increment};
  assign lo_inc   = {1'b0, lo} + {1'b0, cfg.step_increment};
  assign s_dn     = s - cfg.step_increment;
  assign at_floor = ({1'b0, s} <= lo_inc);

  // Waking from sleep clears the counter and the mode before anything else.
  assign mode_eff = cur.asleep ? laau_pkg::MODE_IDLE : cur.ramp_mode;
  assign cnt_eff  = cur.asleep ? '0 : cur.frame_counter;

  always_comb begin
    nxt = cur;
    if (action) begin
      nxt.drive_step  = laau_pkg::DEFAULT_STEP;
      nxt.change_flag = 1'b0;
      nxt.asleep      = 1'b1;
    end else begin
      nxt.asleep        = 1'b0;
      nxt.ramp_mode     = mode_eff;
      nxt.frame_counter = cnt_eff;
      if (cnt_eff <= cfg.frame_skip_threshold) begin
        nxt.frame_counter = cnt_eff + laau_pkg::CNT_W'(1);
        nxt.change_flag   = 1'b0;
      end else begin
        nxt.frame_counter = '0;
        nxt.change_flag   = 1'b0;
        case (mode_eff)
          laau_pkg::MODE_IDLE: begin
            if (exposure_line >= cfg.exposure_entry_high && s < hi) begin
              nxt.ramp_mode   = laau_pkg::MODE_UP;
              nxt.drive_step  = (s_up > {1'b0, hi}) ? hi : s_up[laau_pkg::STEP_W-1:0];
              nxt.change_flag = 1'b1;
            end else if (exposure_line <= cfg.exposure_entry_low && s > lo) begin
              nxt.ramp_mode   = laau_pkg::MODE_DOWN;
              nxt.drive_step  = at_floor ? lo : s_dn;
              nxt.change_flag = 1'b1;
            end
          end
          laau_pkg::MODE_UP: begin
            if (exposure_line > cfg.exposure_keep_high) begin
              nxt.change_flag = 1'b1;
              if (s_up >= {1'b0, hi}) begin
                nxt.ramp_mode  = laau_pkg::MODE_IDLE;
                nxt.drive_step = hi;
              end else begin
                nxt.drive_step = s_up[laau_pkg::STEP_W-1:0];
              end
            end else begin
              nxt.ramp_mode = laau_pkg::MODE_IDLE;
            end
          end
          default: begin
            // Ramp-down; an unused mode code behaves the same way.
            if (exposure_line < cfg.exposure_keep_low) begin
              nxt.change_flag = 1'b1;
              if (at_floor) begin
                nxt.ramp_mode  = laau_pkg::MODE_IDLE;
                nxt.drive_step = lo;
              end else begin
                nxt.ramp_mode  = laau_pkg::MODE_DOWN;
                nxt.drive_step = s_dn;
              end
            end else begin
              nxt.ramp_mode = laau_pkg::MODE_IDLE;
            end
          end
        endcase
      end
    end
  end

endmodule

/* rtl/core/led_current_auto_adjust_unit.sv */
// LED current auto-adjust unit. Each input beat is either a sensor frame with
// its exposure time (in_action = 0) or an enter-sleep request (in_action = 1),
// and each one produces exactly one output beat carrying the LED drive step
// after that beat, a flag that the beat changed the step, and the sleep state.
// Only every (frame_skip_threshold + 2)th frame after wake-up or the last
// decision runs the idle / ramp-up / ramp-down controller; the others only
// count. The block takes one beat per clock: the decision is a handful of
// compares and 6-bit adds between the state registers and the output
// register, so a result appears in the cycle after its beat is accepted; a new
// beat is taken when the output register is empty or being drained in the same cycle.
// Configuration registers are written through cfg_we / cfg_index / cfg_wdata
// and should only be changed while no beat is in flight.
module led_current_auto_adjust_unit (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_we,
  input  logic [laau_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [laau_pkg::CFG_DATA_W-1:0]   cfg_wdata,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic [laau_pkg::EXPO_W-1:0]       in_exposure_line,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [laau_pkg::STEP_W-1:0]       out_led_step,
  output logic                              out_step_changed,
  output logic                              out_sleeping
);

  laau_pkg::cfg_t   cfg;
  laau_pkg::state_t state_r;
  laau_pkg::state_t state_nxt;

  logic                        out_valid_r;
  logic [laau_pkg::STEP_W-1:0] out_led_step_r;
  logic                        out_step_changed_r;
  logic                        out_sleeping_r;
  logic                        in_fire;

  laau_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  laau_step_logic u_step_logic (
    .cfg           (cfg),
    .cur           (state_r),
    .action        (in_action),
    .exposure_line (in_exposure_line),
    .nxt           (state_nxt)
  );

  // The output register may be refilled in the cycle it is drained.
  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.frame_counter <= '0;
      state_r.ramp_mode     <= laau_pkg::MODE_IDLE;
      state_r.drive_step    <= '0;
      state_r.change_flag   <= 1'b0;
      state_r.asleep        <= 1'b0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_led_step_r     <= state_nxt.drive_step;
      out_step_changed_r <= state_nxt.change_flag;
      out_sleeping_r     <= state_nxt.asleep;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led_step     = out_led_step_r;
  assign out_step_changed = out_step_changed_r;
  assign out_sleeping     = out_sleeping_r;

endmodule

/* rtl/core/laau_checker.sv */
module laau_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_action,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [laau_pkg::STEP_W-1:0]       out_led_step,
  input  logic                              out_step_changed,
  input  logic                              out_sleeping
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_step)
      && $stable(out_step_changed) && $stable(out_sleeping))
    else $error("stalled result beat changed");

  // Every accepted beat shows up as a result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  // Enter-sleep loads the default step without flagging a change.
  a_sleep_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action |=> out_sleeping && !out_step_changed
      && out_led_step == laau_pkg::DEFAULT_STEP)
    else $error("enter-sleep result wrong");

  // With the output register empty the input side never stalls.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A frame that wakes the block only counts; a sleep beat never flags a change.
  a_no_change_asleep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_step_changed && out_sleeping))
    else $error("step change flagged while asleep");

endmodule

bind led_current_auto_adjust_unit laau_checker u_laau_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_action        (in_action),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_led_step     (out_led_step),
  .out_step_changed (out_step_changed),
  .out_sleeping     (out_sleeping)
);
